[rtl/core/oale_pkg.sv]
package oale_pkg;

  // Field widths fixed by the request and result formats
  localparam int TYPE_W = 2;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd2;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_req;  // capture the accepted request
    logic rd_pos;    // read the entry at the request position
    logic start;     // set up the shift pointers
    logic step;      // move one entry: read at the pointer, write the pending word
    logic drain;     // write the last pending word
    logic finish;    // apply the request and load the result register
  } oale_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ok;          // request passes its checks
    logic is_find;     // request is a find
    logic needs_shift; // later entries have to move
    logic last;        // pointer sits on the last entry to move
    logic out_free;    // result register can take a new result
  } oale_stat_t;

endpackage

[rtl/core/oale_ctrl.sv]
module oale_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  oale_pkg::oale_stat_t  stat,
  output oale_pkg::oale_cmd_t   cmd
);
  import oale_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Take a request only while no other one is in flight
  assign in_stall = (state_r != ST_IDLE);

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stat.ok) begin
          state_nxt = ST_FINAL;
        end else if (stat.is_find) begin
          cmd.rd_pos = 1'b1;
          state_nxt  = ST_FINAL;
        end else if (stat.needs_shift) begin
          cmd.start = 1'b1;
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_SHIFT: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/oale_dp.sv]
module oale_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [oale_pkg::TYPE_W-1:0]   in_req_type,
  input  logic [oale_pkg::POS_W-1:0]    in_position,
  input  logic [oale_pkg::DATA_W-1:0]   in_value,
  input  logic                          cfg_valid,
  input  logic [oale_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [oale_pkg::DATA_W-1:0]   out_read_value,
  output logic [oale_pkg::CNT_W-1:0]    out_length,
  input  oale_pkg::oale_cmd_t           cmd,
  output oale_pkg::oale_stat_t          stat
);
  import oale_pkg::*;

  localparam int          IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int          LIM_W   = 9;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
  localparam logic [POS_W-1:0] POS_FRONT = '1;

  // Entry store
  logic [DATA_W-1:0] mem [MAX_ENTRIES];
  logic [DATA_W-1:0] rd_data_r;

  // Request and list state
  logic [TYPE_W-1:0] req_type_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  wr_addr_r;
  logic              wr_pend_r;

  // Result register
  logic              out_valid_r;
  logic              out_status_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic [CNT_W-1:0]  out_length_r;

  logic              is_insert;
  logic              is_delete;
  logic              pos_in_rng;
  logic              pos_front;
  logic              room;
  logic              req_ok;
  logic [CNT_W-1:0]  slot;
  logic [CNT_W-1:0]  count_m1;
  logic [LIM_W-1:0]  cap_ext;
  logic [LIM_W-1:0]  limit;

  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Check the request against the list
  always_comb begin
    is_insert  = (req_type_r == REQ_INSERT);
    is_delete  = (req_type_r == REQ_DELETE);
    pos_in_rng = !pos_r[POS_W-1] && (pos_r < count_r);
    pos_front  = (pos_r == POS_FRONT);
    slot       = pos_r + 5'd1;
    count_m1   = count_r - 5'd1;
    cap_ext    = LIM_W'(cap_r);
    limit      = (cap_ext < MAX_LIM) ? cap_ext : MAX_LIM;
    room       = (LIM_W'(count_r) < limit);
    case (req_type_r)
      REQ_FIND:   req_ok = pos_in_rng;
      REQ_INSERT: req_ok = (pos_in_rng || pos_front) && room;
      REQ_DELETE: req_ok = pos_in_rng;
      default:    req_ok = 1'b0;
    endcase
  end

  always_comb begin
    stat.ok          = req_ok;
    stat.is_find     = (req_type_r == REQ_FIND);
    stat.needs_shift = (slot < count_r);
    stat.last        = is_insert ? (ptr_r == slot) : (ptr_r == count_m1);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // Select memory read and write
  always_comb begin
    mem_re    = cmd.rd_pos || cmd.step;
    mem_raddr = cmd.step ? IDX_W'(ptr_r) : IDX_W'(pos_r);
    mem_we    = ((cmd.step || cmd.drain) && wr_pend_r) ||
                (cmd.finish && req_ok && is_insert);
    mem_waddr = cmd.finish ? IDX_W'(slot) : IDX_W'(wr_addr_r);
    mem_wdata = cmd.finish ? value_r : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      pos_r      <= in_position;
      value_r    <= in_value;
    end
  end

  // Advance the shift pointers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_r <= is_insert ? count_m1 : slot;
    end else if (cmd.step) begin
      ptr_r     <= is_insert ? (ptr_r - 5'd1) : (ptr_r + 5'd1);
      wr_addr_r <= is_insert ? (ptr_r + 5'd1) : (ptr_r - 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else if (cmd.start || cmd.drain) begin
      wr_pend_r <= 1'b0;
    end else if (cmd.step) begin
      wr_pend_r <= 1'b1;
    end
  end

  // Update the length and the capacity
  always_comb begin
    count_nxt = count_r;
    if (req_ok && is_insert) begin
      count_nxt = count_r + 5'd1;
    end else if (req_ok && is_delete) begin
      count_nxt = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Load and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r     <= req_ok ? STATUS_OK : STATUS_ERR;
      out_read_value_r <= (req_ok && stat.is_find) ? rd_data_r : '0;
      out_length_r     <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_length     = out_length_r;

endmodule

[rtl/core/ordered_array_list_engine.sv]
// Positional list engine: find, insert-after and delete on a list of up to
// MAX_ENTRIES 32-bit words, limited further by the capacity register.
// Input channel (in_valid / in_stall): one request per transfer with
// in_req_type, in_position (signed, -1 = front for insert) and in_value.
// Output channel (out_valid / out_stall): one result per request with
// out_status (0 ok, 1 error), out_read_value and out_length.
// Config channel (cfg_valid / cfg_ready, always ready): writes capacity;
// write only while no request is in flight.
// Timing: one request at a time. A find or any rejected request passes EVAL
// and FINAL; the result register is loaded as FINAL ends. Insert and delete
// pass EVAL, SHIFT, DRAIN and FINAL when entries move, else EVAL and FINAL;
// the entry memory has one read and one write port and moves one entry per
// cycle, so the count of entries to move (at most the length) sets the rate.
// Reset clears the length, sets capacity to 16 and empties the result
// register; entry contents are not cleared. The result register frees the
// engine from the receiver: the next request is taken while a result waits,
// and only the final step of that request waits out a stall on the output.
module ordered_array_list_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [oale_pkg::TYPE_W-1:0]         in_req_type,
  input  logic signed [oale_pkg::POS_W-1:0]   in_position,
  input  logic signed [oale_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_status,
  output logic signed [oale_pkg::DATA_W-1:0]  out_read_value,
  output logic [oale_pkg::CNT_W-1:0]          out_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [oale_pkg::CNT_W-1:0]          cfg_data
);
  import oale_pkg::*;

  oale_cmd_t  cmd;
  oale_stat_t stat;

  assign cfg_ready = 1'b1;

  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  oale_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

[test/ordered_array_list_engine_tb.sv]
`timescale 1ns / 1ps

module ordered_array_list_engine_tb;
  import oale_pkg::*;

  localparam int LIST_DEPTH     = 16;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 300;

  // Request code the block must reject
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         length;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [TYPE_W-1:0]         in_req_type = '0;
  logic signed [POS_W-1:0]   in_position = '0;
  logic signed [DATA_W-1:0]  in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_status;
  logic signed [DATA_W-1:0]  out_read_value;
  logic [CNT_W-1:0]          out_length;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CNT_W-1:0]          cfg_data = '0;

  // Shadow copy of the list and the capacity register
  logic [DATA_W-1:0] list_mem [LIST_DEPTH];
  int                list_len;
  logic [CNT_W-1:0]  cap_reg;

  list_result_t expected_results [$];
  list_result_t due;
  int           error_count = 0;
  bit           steady_flow = 1'b0;
  int           hold_request = 0;
  int           hold_left = 0;
  int           idle_cycles = 0;

  ordered_array_list_engine #(
    .MAX_ENTRIES(LIST_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the result it produces
  function automatic list_result_t apply_request(logic [TYPE_W-1:0] kind,
                                                 logic signed [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] val);
    list_result_t res;
    int p;
    int lim;
    int k;
    p = pos;
    lim = (cap_reg < LIST_DEPTH) ? cap_reg : LIST_DEPTH;
    res.status = STATUS_ERR;
    res.read_value = '0;
    case (kind)
      REQ_FIND: begin
        if (p >= 0 && p < list_len) begin
          res.read_value = list_mem[p];
          res.status = STATUS_OK;
        end
      end
      REQ_INSERT: begin
        if (p >= -1 && p < list_len && list_len < lim) begin
          for (k = list_len; k > p + 1; k--)
            list_mem[k] = list_mem[k-1];
          list_mem[p+1] = val;
          list_len++;
          res.status = STATUS_OK;
        end
      end
      REQ_DELETE: begin
        if (p >= 0 && p < list_len) begin
          for (k = p + 1; k < list_len; k++)
            list_mem[k-1] = list_mem[k];
          list_len--;
          res.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    res.length = list_len[CNT_W-1:0];
    return res;
  endfunction

  // Offer one request, hold it until the transfer, then record its result
  task automatic send_request(logic [TYPE_W-1:0] kind, logic signed [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    while (!steady_flow && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_request(kind, pos, val));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write capacity only once the engine has gone quiet
  task automatic set_capacity(logic [CNT_W-1:0] cap);
    drain_and_settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = cap;
  endtask

  // Mostly well-formed positions against the current length, some noise
  task automatic send_random(int n);
    logic [TYPE_W-1:0]        kind;
    logic signed [POS_W-1:0]  pos;
    logic signed [DATA_W-1:0] val;
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)
        kind = REQ_UNKNOWN;
      else if (roll < 42)
        kind = REQ_INSERT;
      else if (roll < 70)
        kind = REQ_FIND;
      else
        kind = REQ_DELETE;
      if ($urandom_range(0, 99) < 15 || (kind != REQ_INSERT && list_len == 0))
        pos = POS_W'($urandom_range(0, 31));
      else if (kind == REQ_INSERT)
        pos = POS_W'($urandom_range(0, list_len) - 1);
      else
        pos = POS_W'($urandom_range(0, list_len - 1));
      case ($urandom_range(0, 15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = '0;
        3:       val = '1;
        default: val = $urandom;
      endcase
      send_request(kind, pos, val);
    end
  endtask

  // Empty list, front and back inserts, bad positions, unknown request
  task automatic test_directed_edges();
    send_request(REQ_FIND,   5'sd0,  32'h1234_5678);
    send_request(REQ_DELETE, 5'sd0,  32'h0);
    send_request(REQ_INSERT, 5'sd0,  32'h5555_5555);
    send_request(REQ_INSERT, -5'sd1, 32'h8000_0000);
    send_request(REQ_INSERT, 5'sd0,  32'h7FFF_FFFF);
    send_request(REQ_INSERT, -5'sd1, 32'h0000_0000);
    send_request(REQ_INSERT, 5'sd2,  32'hFFFF_FFFF);
    send_request(REQ_INSERT, -5'sd2, 32'hAAAA_AAAA);
    send_request(REQ_INSERT, -5'sd16, 32'h0F0F_0F0F);
    send_request(REQ_FIND,   -5'sd1, 32'h0);
    send_request(REQ_FIND,   5'sd15, 32'h0);
    send_request(REQ_FIND,   5'sd0,  32'h0);
    send_request(REQ_FIND,   5'sd1,  32'hFFFF_FFFF);
    send_request(REQ_FIND,   5'sd2,  32'h0);
    send_request(REQ_FIND,   5'sd3,  32'h0);
    send_request(REQ_FIND,   5'sd4,  32'h0);
    send_request(REQ_UNKNOWN, 5'sd0, 32'hDEAD_BEEF);
    send_request(REQ_DELETE, 5'sd3,  32'h0);
    send_request(REQ_DELETE, 5'sd0,  32'h0);
    send_request(REQ_DELETE, 5'sd5,  32'h0);
    send_request(REQ_DELETE, -5'sd16, 32'h0);
    send_request(REQ_FIND,   5'sd0,  32'h0);
    send_request(REQ_FIND,   5'sd1,  32'h0);
    drain_and_settle();
  endtask

  // Capacity below the length, zero, saturation above the depth, full list
  task automatic test_capacity_limits();
    int i;
    set_capacity(5'd1);
    send_request(REQ_INSERT, -5'sd1, 32'h0000_0001);
    while (list_len != 0) send_request(REQ_DELETE, 5'sd0, 32'h0);
    send_request(REQ_INSERT, -5'sd1, 32'h0000_0002);
    send_request(REQ_INSERT, 5'sd0,  32'h0000_0003);
    set_capacity(5'd0);
    send_request(REQ_INSERT, -5'sd1, 32'h0000_0004);
    send_request(REQ_DELETE, 5'sd0,  32'h0);
    send_request(REQ_INSERT, -5'sd1, 32'h0000_0005);
    set_capacity(5'd31);
    for (i = 0; i < LIST_DEPTH + 2; i++)
      send_request(REQ_INSERT, POS_W'($urandom_range(0, list_len) - 1), $urandom);
    send_request(REQ_INSERT, 5'sd15, 32'h0000_0006);
    send_request(REQ_FIND,   5'sd15, 32'h0);
    send_request(REQ_DELETE, 5'sd15, 32'h0);
    send_request(REQ_INSERT, 5'sd14, 32'h0000_0007);
    send_request(REQ_DELETE, 5'sd0,  32'h0);
    set_capacity(5'd16);
  endtask

  // Random traffic across several capacities, with a drain in the middle
  task automatic test_random_traffic();
    send_random(125);
    pause_until_drained();
    send_random(125);
    set_capacity(5'd31);
    steady_flow = 1'b1;
    send_random(100);
    steady_flow = 1'b0;
    set_capacity(5'd4);
    send_random(100);
    set_capacity(5'd0);
    send_random(40);
    set_capacity(CNT_W'($urandom_range(1, 16)));
    send_random(90);
    set_capacity(CNT_W'($urandom_range(1, 16)));
    send_random(80);
    set_capacity(5'd16);
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    steady_flow = 1'b1;
    hold_request = HOLD_OFF_LEN;
    send_random(40);
    pause_until_drained();
    steady_flow = 1'b0;
  endtask

  // Receiver: random stalls, stall-free stretches and a counted hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(0, 99) < 27);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: status %0d value %0d length %0d", $time,
                 out_status, out_read_value, out_length);
        error_count++;
      end else begin
        due = expected_results.pop_front();
        if (out_status !== due.status) begin
          $display("%0t status mismatch: expected %0d, got %0d", $time,
                   due.status, out_status);
          error_count++;
        end
        if (out_read_value !== due.read_value) begin
          $display("%0t read_value mismatch: expected %0d, got %0d", $time,
                   due.read_value, out_read_value);
          error_count++;
        end
        if (out_length !== due.length) begin
          $display("%0t length mismatch: expected %0d, got %0d", $time,
                   due.length, out_length);
          error_count++;
        end
      end
    end
  end

  // Stop the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("ordered_array_list_engine_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    list_len = 0;
    cap_reg = 5'd16;
    foreach (list_mem[k]) list_mem[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();
    drain_and_settle();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ordered_array_list_engine_tb: PASS");
    end else begin
      $display("ordered_array_list_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/oale_pkg.sv
rtl/core/oale_ctrl.sv
rtl/core/oale_dp.sv
rtl/core/ordered_array_list_engine.sv
test/ordered_array_list_engine_tb.sv
